@@ design/distinct_subsequence_counter_unit_defines.svh @@
// ----------------------------------------------------------------------------
// distinct_subsequence_counter_unit_defines
// Assertion macros for the checker file of the counter unit.
// ----------------------------------------------------------------------------
`ifndef DISTINCT_SUBSEQUENCE_COUNTER_UNIT_DEFINES_SVH
`define DISTINCT_SUBSEQUENCE_COUNTER_UNIT_DEFINES_SVH

// checked outside reset
`define DSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked through reset as well
`define DSC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ design/dsc_pkg.sv @@
// ----------------------------------------------------------------------------
// dsc_pkg
// Widths, constants and shared types of the distinct subsequence counter.
// ----------------------------------------------------------------------------
package dsc_pkg;

    localparam int VAL_W     = 30;
    localparam int SYM_W     = 8;
    localparam int ALPHA     = 256;
    localparam int ADDR_W    = $clog2(ALPHA);
    localparam int SWP_W     = $clog2(ALPHA + 1);
    localparam int RED_CNT_W = $clog2(VAL_W + 1);

    localparam logic [VAL_W-1:0] MOD_RESET = VAL_W'(1000000007);
    localparam logic [VAL_W-1:0] MOD_MIN   = VAL_W'(2);

    typedef enum logic [2:0] {
        SW_IDLE,
        SW_READ,
        SW_LOAD,
        SW_RUN,
        SW_WRITE
    } t_sweep_state;

    typedef struct packed {
        logic              busy;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic              p_we;
        logic [VAL_W-1:0]  p_data;
    } t_sweep_ctl;

endpackage

@@ design/dsc_ram.sv @@
// ----------------------------------------------------------------------------
// dsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/dsc_reduce.sv @@
// ----------------------------------------------------------------------------
// dsc_reduce
// Bit-serial remainder unit: value mod modulus, one bit per cycle.
// ----------------------------------------------------------------------------
module dsc_reduce (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [dsc_pkg::VAL_W-1:0] i_value,
    input  logic [dsc_pkg::VAL_W-1:0] i_mod,
    output logic                      o_done,
    output logic [dsc_pkg::VAL_W-1:0] o_result
);
    import dsc_pkg::*;

    logic [RED_CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0]     r_acc;
    logic [VAL_W-1:0]     r_rem;
    logic [VAL_W:0]       n_trial;
    logic [VAL_W:0]       n_diff;
    logic [VAL_W-1:0]     n_rem;

    always_comb begin
        n_trial = {r_rem, r_acc[VAL_W-1]};
        n_diff  = n_trial - {1'b0, i_mod};
        n_rem   = (n_trial >= {1'b0, i_mod}) ? n_diff[VAL_W-1:0] : n_trial[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= RED_CNT_W'(VAL_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - RED_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_acc <= i_value;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_acc <= {r_acc[VAL_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done   = (r_cnt == '0);
    assign o_result = r_rem;

endmodule

@@ design/dsc_sweep.sv @@
// ----------------------------------------------------------------------------
// dsc_sweep
// Re-reduction pass after a modulus write: every table entry and the prefix
// sum are brought below the new modulus.
// ----------------------------------------------------------------------------
module dsc_sweep (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [dsc_pkg::VAL_W-1:0] i_mod,
    input  logic [dsc_pkg::VAL_W-1:0] i_p,
    input  logic [dsc_pkg::VAL_W-1:0] i_rdata,
    output dsc_pkg::t_sweep_ctl       o_ctl
);
    import dsc_pkg::*;

    t_sweep_state     r_state;
    t_sweep_state     n_state;
    logic [SWP_W-1:0] r_idx;
    logic [SWP_W-1:0] n_idx;
    logic             w_is_p;
    logic             w_red_load;
    logic             w_red_done;
    logic [VAL_W-1:0] w_red_value;
    logic [VAL_W-1:0] w_red_result;

    assign w_is_p = (r_idx == SWP_W'(ALPHA));

    dsc_reduce u_reduce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_red_load),
        .i_value  (w_red_value),
        .i_mod    (i_mod),
        .o_done   (w_red_done),
        .o_result (w_red_result)
    );

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        priority if (i_cfg_we) begin
            n_state = SW_READ;
            n_idx   = '0;
        end else begin
            unique case (r_state)
                SW_IDLE:  n_state = SW_IDLE;
                SW_READ:  n_state = SW_LOAD;
                SW_LOAD:  n_state = SW_RUN;
                SW_RUN: begin
                    if (w_red_done) begin
                        n_state = SW_WRITE;
                    end
                end
                SW_WRITE: begin
                    if (w_is_p) begin
                        n_state = SW_IDLE;
                    end else begin
                        n_state = SW_READ;
                        n_idx   = r_idx + SWP_W'(1);
                    end
                end
                default:  n_state = SW_IDLE;
            endcase
        end
    end

    always_comb begin
        w_red_load   = (r_state == SW_LOAD);
        w_red_value  = w_is_p ? i_p : i_rdata;
        o_ctl.busy   = (r_state != SW_IDLE);
        o_ctl.raddr  = r_idx[ADDR_W-1:0];
        o_ctl.we     = (r_state == SW_WRITE) && !w_is_p;
        o_ctl.waddr  = r_idx[ADDR_W-1:0];
        o_ctl.wdata  = w_red_result;
        o_ctl.p_we   = (r_state == SW_WRITE) && w_is_p;
        o_ctl.p_data = w_red_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SW_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

@@ design/distinct_subsequence_counter_unit.sv @@
// ----------------------------------------------------------------------------
// distinct_subsequence_counter_unit
// Running count of distinct non-empty subsequences modulo a programmable
// modulus, one symbol per transaction.
// ----------------------------------------------------------------------------
// Takes one symbol per cycle unless an output stall, modulus write or
// re-reduction pass holds it; it is registered into the second stage, its
// result into the output register. The per-symbol table RAM is read in the
// accept cycle and written back as the symbol leaves the second stage,
// with a bypass for a repeated symbol. A second RAM and register keep every
// table entry and the prefix sum as written. Writing the modulus starts a
// re-reduction pass that reduces each of the 256 kept entries and the kept
// prefix sum by the new modulus into the working table through a
// bit-serial remainder unit, during which no input transaction is taken.
// The user must write the modulus only while no transaction is in flight;
// the block does not check this. Values 0 and 1 act as 2.
module distinct_subsequence_counter_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [dsc_pkg::SYM_W-1:0] i_symbol,
    input  logic                      i_start_req,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [dsc_pkg::VAL_W-1:0] o_running_count,
    output logic [dsc_pkg::VAL_W-1:0] o_new_endings,
    input  logic                      i_cfg_we,
    input  logic [dsc_pkg::VAL_W-1:0] i_cfg_wdata
);
    import dsc_pkg::*;

    t_sweep_ctl        w_sw;
    logic [VAL_W-1:0]  r_mod;
    logic [VAL_W-1:0]  r_p;
    logic [VAL_W-1:0]  r_p_base;
    logic [ALPHA-1:0]  r_seen;
    logic [ALPHA-1:0]  n_seen;

    logic              r_v1;
    logic [ADDR_W-1:0] r_idx1;
    logic              r_start1;
    logic              r_seen1;
    logic              r_fwd1;
    logic [VAL_W-1:0]  r_fwd_data1;

    logic              r_vo;
    logic [VAL_W-1:0]  r_cnt_o;
    logic [VAL_W-1:0]  r_new_o;

    logic [ADDR_W-1:0] w_idx_in;
    logic              w_adv1;
    logic              w_acc;
    logic [VAL_W-1:0]  w_p_use;
    logic [VAL_W-1:0]  w_d_use;
    logic [VAL_W-1:0]  w_rdata;
    logic [VAL_W-1:0]  w_base_rdata;
    logic [VAL_W:0]    w_sub;
    logic [VAL_W:0]    w_sub_wrap;
    logic [VAL_W:0]    w_inc;
    logic [VAL_W:0]    w_inc_wrap;
    logic [VAL_W-1:0]  w_fresh;
    logic [VAL_W:0]    w_sum;
    logic [VAL_W:0]    w_sum_wrap;
    logic [VAL_W-1:0]  w_newp;

    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_waddr;
    logic [VAL_W-1:0]  w_ram_wdata;
    logic [ADDR_W-1:0] w_ram_raddr;

    assign w_idx_in   = i_symbol[ADDR_W-1:0];
    assign w_adv1     = r_v1 && (!r_vo || i_out_ready);
    assign o_in_ready = !w_sw.busy && !i_cfg_we && (!r_v1 || w_adv1);
    assign w_acc      = i_in_valid && o_in_ready;

    // modular arithmetic of the second stage
    always_comb begin
        w_p_use    = r_start1 ? '0 : r_p;
        w_d_use    = r_fwd1 ? r_fwd_data1 : w_rdata;
        w_sub      = {1'b0, w_p_use} - {1'b0, w_d_use};
        w_sub_wrap = w_sub + {1'b0, r_mod};
        w_inc      = {1'b0, w_p_use} + (VAL_W+1)'(1);
        w_inc_wrap = w_inc - {1'b0, r_mod};
        if (r_seen1) begin
            w_fresh = w_sub[VAL_W] ? w_sub_wrap[VAL_W-1:0] : w_sub[VAL_W-1:0];
        end else begin
            w_fresh = (w_inc >= {1'b0, r_mod}) ? w_inc_wrap[VAL_W-1:0] : w_inc[VAL_W-1:0];
        end
        w_sum      = {1'b0, w_p_use} + {1'b0, w_fresh};
        w_sum_wrap = w_sum - {1'b0, r_mod};
        w_newp     = (w_sum >= {1'b0, r_mod}) ? w_sum_wrap[VAL_W-1:0] : w_sum[VAL_W-1:0];
    end

    always_comb begin
        n_seen = r_seen;
        if (w_acc) begin
            if (i_start_req) begin
                n_seen = '0;
            end
            n_seen[w_idx_in] = 1'b1;
        end
    end

    always_comb begin
        w_ram_we    = w_sw.busy ? w_sw.we    : w_adv1;
        w_ram_waddr = w_sw.busy ? w_sw.waddr : r_idx1;
        w_ram_wdata = w_sw.busy ? w_sw.wdata : w_p_use;
        if (w_sw.busy) begin
            w_ram_raddr = w_sw.raddr;
        end else if (w_acc) begin
            w_ram_raddr = w_idx_in;
        end else begin
            w_ram_raddr = r_idx1;
        end
    end

    // working table, reduced by the current modulus
    dsc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ALPHA)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rdata)
    );

    // entries as written, source of the re-reduction pass
    dsc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ALPHA)
    ) u_ram_base (
        .i_clk   (i_clk),
        .i_we    (w_adv1),
        .i_waddr (r_idx1),
        .i_wdata (w_p_use),
        .i_raddr (w_sw.raddr),
        .o_rdata (w_base_rdata)
    );

    dsc_sweep u_sweep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_we (i_cfg_we),
        .i_mod    (r_mod),
        .i_p      (r_p_base),
        .i_rdata  (w_base_rdata),
        .o_ctl    (w_sw)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod    <= MOD_RESET;
            r_p      <= '0;
            r_p_base <= '0;
            r_seen   <= '0;
            r_v1     <= 1'b0;
            r_vo     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mod <= (i_cfg_wdata < MOD_MIN) ? MOD_MIN : i_cfg_wdata;
            end
            if (w_sw.p_we) begin
                r_p <= w_sw.p_data;
            end else if (w_adv1) begin
                r_p <= w_newp;
            end
            if (w_adv1) begin
                r_p_base <= w_newp;
            end
            r_seen <= n_seen;
            if (w_acc) begin
                r_v1 <= 1'b1;
            end else if (w_adv1) begin
                r_v1 <= 1'b0;
            end
            if (w_adv1) begin
                r_vo <= 1'b1;
            end else if (i_out_ready) begin
                r_vo <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_idx1      <= w_idx_in;
            r_start1    <= i_start_req;
            r_seen1     <= !i_start_req && r_seen[w_idx_in];
            r_fwd1      <= r_v1 && (r_idx1 == w_idx_in);
            r_fwd_data1 <= w_p_use;
        end
        if (w_adv1) begin
            r_cnt_o <= w_newp;
            r_new_o <= w_fresh;
        end
    end

    assign o_out_valid     = r_vo;
    assign o_running_count = r_cnt_o;
    assign o_new_endings   = r_new_o;

endmodule

@@ design/dsc_checker.sv @@
// ----------------------------------------------------------------------------
// dsc_checker
// Port-level checks of the counter unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "distinct_subsequence_counter_unit_defines.svh"

module dsc_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      o_in_ready,
    input  logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  logic [dsc_pkg::VAL_W-1:0] o_running_count,
    input  logic [dsc_pkg::VAL_W-1:0] o_new_endings,
    input  logic                      i_cfg_we
);

    `DSC_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped while stalled")
    `DSC_ASSERT(a_out_stable, o_out_valid && !i_out_ready |=> $stable({o_running_count, o_new_endings}), "stalled result changed")
    `DSC_ASSERT(a_cfg_blocks, i_cfg_we |=> !o_in_ready, "input taken during re-reduction pass")
    `DSC_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out_valid, "result present after reset")

endmodule

bind distinct_subsequence_counter_unit dsc_checker u_dsc_checker (.*);

@@ verif/distinct_subsequence_counter_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distinct_subsequence_counter_unit_tb
// Streams symbol strings into the counter with random gaps and output
// stalls, across a range of modulus settings including the degenerate and
// full-scale values. Every result transaction is checked field by field
// against an in-bench model of the count, or against a typed value for the
// simplest directed rows.
// ----------------------------------------------------------------------------
module distinct_subsequence_counter_unit_tb;

    import dsc_pkg::*;

    localparam int ITEMS_PER_PHASE = 50;
    localparam int N_PHASES        = 10;
    localparam int N_DIRECTED      = 25;
    localparam int MAX_GAP         = 9;
    localparam int LONG_HOLD       = 300;
    localparam int HOLD_AFTER      = 200;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 8;

    typedef enum logic {
        ROW_SYMBOL,
        ROW_MODULUS
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [VAL_W-1:0] value;
        logic             start;
        logic             known;
        logic [VAL_W-1:0] count;
        logic [VAL_W-1:0] fresh;
    } t_stim_row;

    typedef struct packed {
        logic [VAL_W-1:0] count;
        logic [VAL_W-1:0] fresh;
    } t_count_pair;

    localparam logic [VAL_W-1:0] MOD_FULL = {VAL_W{1'b1}};

    // typed rows: fresh string at 10^9+7 or after a start flag
    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{ROW_SYMBOL,  30'd0,    1'b0, 1'b1, 30'd1, 30'd1},
        '{ROW_SYMBOL,  30'd0,    1'b0, 1'b1, 30'd2, 30'd1},
        '{ROW_SYMBOL,  30'd255,  1'b0, 1'b1, 30'd5, 30'd3},
        '{ROW_SYMBOL,  30'd0,    1'b0, 1'b1, 30'd9, 30'd4},
        '{ROW_SYMBOL,  30'd255,  1'b1, 1'b1, 30'd1, 30'd1},
        '{ROW_SYMBOL,  30'd128,  1'b0, 1'b1, 30'd3, 30'd2},
        '{ROW_MODULUS, 30'd0,    1'b0, 1'b0, 30'd0, 30'd0},
        '{ROW_SYMBOL,  30'd128,  1'b0, 1'b0, 30'd0, 30'd0},
        '{ROW_SYMBOL,  30'd7,    1'b0, 1'b0, 30'd0, 30'd0},
        '{ROW_SYMBOL,  30'd7,    1'b1, 1'b1, 30'd1, 30'd1},
        '{ROW_SYMBOL,  30'd8,    1'b0, 1'b0, 30'd0, 30'd0},
        '{ROW_MODULUS, 30'd1,    1'b0, 1'b0, 30'd0, 30'd0},
        '{ROW_SYMBOL,  30'd170,  1'b0, 1'b0, 30'd0, 30'd0},
        '{ROW_SYMBOL,  30'd85,   1'b0, 1'b0, 30'd0, 30'd0},
        '{ROW_MODULUS, MOD_FULL, 1'b0, 1'b0, 30'd0, 30'd0},
        '{ROW_SYMBOL,  30'd255,  1'b1, 1'b1, 30'd1, 30'd1},
        '{ROW_SYMBOL,  30'd1,    1'b0, 1'b0, 30'd0, 30'd0},
        '{ROW_SYMBOL,  30'd2,    1'b0, 1'b0, 30'd0, 30'd0},
        '{ROW_SYMBOL,  30'd1,    1'b0, 1'b0, 30'd0, 30'd0},
        '{ROW_SYMBOL,  30'd2,    1'b0, 1'b0, 30'd0, 30'd0},
        '{ROW_SYMBOL,  30'd3,    1'b0, 1'b0, 30'd0, 30'd0},
        '{ROW_MODULUS, MOD_RESET, 1'b0, 1'b0, 30'd0, 30'd0},
        '{ROW_SYMBOL,  30'd254,  1'b1, 1'b1, 30'd1, 30'd1},
        '{ROW_SYMBOL,  30'd254,  1'b0, 1'b1, 30'd2, 30'd1},
        '{ROW_SYMBOL,  30'd15,   1'b0, 1'b0, 30'd0, 30'd0}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [SYM_W-1:0] i_symbol;
    logic             i_start_req;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [VAL_W-1:0] o_running_count;
    logic [VAL_W-1:0] o_new_endings;
    logic             i_cfg_we;
    logic [VAL_W-1:0] i_cfg_wdata;

    // typed expectation travelling with the current input transaction
    logic             typed_known;
    logic [VAL_W-1:0] typed_count;
    logic [VAL_W-1:0] typed_fresh;

    // count model
    logic [VAL_W-1:0] model_modulus = MOD_RESET;
    logic [VAL_W-1:0] model_prefix  = '0;
    logic [VAL_W-1:0] model_last_sum [ALPHA];
    logic [ALPHA-1:0] model_seen    = '0;

    t_count_pair pending_counts [$];

    bit no_idle = 1'b0;
    int n_symbols = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_strings = 0;
    int n_repeats = 0;
    int n_mod_writes = 0;

    distinct_subsequence_counter_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_symbol        (i_symbol),
        .i_start_req     (i_start_req),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_running_count (o_running_count),
        .o_new_endings   (o_new_endings),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("distinct_subsequence_counter_unit_tb NOT OK");
        $finish;
    end

    function automatic t_count_pair count_symbol(logic [SYM_W-1:0] sym, logic start);
        logic [63:0] m;
        logic [63:0] p;
        logic [63:0] fresh;
        t_count_pair r;
        m = (model_modulus < MOD_MIN) ? 64'(MOD_MIN) : 64'(model_modulus);
        if (start) begin
            model_prefix = '0;
            model_seen   = '0;
        end
        p = 64'(model_prefix) % m;
        if (model_seen[sym]) begin
            fresh = (p + m - (64'(model_last_sum[sym]) % m)) % m;
            n_repeats++;
        end else begin
            fresh = (64'd1 + p) % m;
        end
        model_last_sum[sym] = VAL_W'(p);
        model_seen[sym]     = 1'b1;
        model_prefix        = VAL_W'((p + fresh) % m);
        r.count = model_prefix;
        r.fresh = VAL_W'(fresh);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_count_pair predicted;
        t_count_pair oldest;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                model_modulus = i_cfg_wdata;
            end
            if (i_in_valid && o_in_ready) begin
                predicted = count_symbol(i_symbol, i_start_req);
                if (typed_known) begin
                    predicted.count = typed_count;
                    predicted.fresh = typed_fresh;
                end
                pending_counts.push_back(predicted);
                n_symbols++;
                if (i_start_req) n_strings++;
            end
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (pending_counts.size() == 0) begin
                    n_errors++;
                    $display("%0t: result transaction with nothing pending: count %0d new %0d",
                             $time, o_running_count, o_new_endings);
                end else begin
                    oldest = pending_counts.pop_front();
                    if (o_running_count !== oldest.count) begin
                        n_errors++;
                        $display("%0t: running_count expected %0d actual %0d",
                                 $time, oldest.count, o_running_count);
                    end
                    if (o_new_endings !== oldest.fresh) begin
                        n_errors++;
                        $display("%0t: new_endings expected %0d actual %0d",
                                 $time, oldest.fresh, o_new_endings);
                    end
                end
            end
        end
    end

    // result side: random stall per transaction, one long hold-off
    initial begin
        int  stall;
        bit  hold_done;
        hold_done   = 1'b0;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_results >= HOLD_AFTER) begin
                stall     = LONG_HOLD;
                hold_done = 1'b1;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // entered and left at a falling edge
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic start,
                               input logic known, input logic [VAL_W-1:0] count,
                               input logic [VAL_W-1:0] fresh);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_symbol    <= sym;
        i_start_req <= start;
        typed_known <= known;
        typed_count <= count;
        typed_fresh <= fresh;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        @(negedge i_clk);
    endtask

    task automatic write_modulus(input logic [VAL_W-1:0] value);
        i_in_valid <= 1'b0;
        while (pending_counts.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_mod_writes++;
    endtask

    initial begin
        logic [VAL_W-1:0] phase_moduli [N_PHASES];
        logic [SYM_W-1:0] base;
        logic [SYM_W-1:0] sym;
        int               width;
        logic             start;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_symbol    = '0;
        i_start_req = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        typed_known = 1'b0;
        typed_count = '0;
        typed_fresh = '0;
        base        = '0;
        width       = ALPHA;

        phase_moduli = '{MOD_RESET, MOD_MIN, MOD_FULL, 30'd3, 30'd0, 30'd998244353,
                         30'd0, 30'd1, 30'd65537, MOD_RESET};
        phase_moduli[6] = VAL_W'($urandom_range(2, MOD_FULL));

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[r]) begin
            if (DIRECTED_ROWS[r].kind == ROW_MODULUS) begin
                write_modulus(DIRECTED_ROWS[r].value);
            end else begin
                send_symbol(DIRECTED_ROWS[r].value[SYM_W-1:0], DIRECTED_ROWS[r].start,
                            DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].count,
                            DIRECTED_ROWS[r].fresh);
            end
        end

        // strings run across phase boundaries, so most changes land mid-string
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_modulus(phase_moduli[ph]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
                start = (ph == 0 && k == 0) || ($urandom_range(0, 39) == 0);
                if (start) begin
                    base = SYM_W'($urandom_range(0, ALPHA - 1));
                    case ($urandom_range(0, 3))
                        0: width = $urandom_range(1, 2);
                        1: width = 4;
                        2: width = 16;
                        default: width = ALPHA;
                    endcase
                end
                if ($urandom_range(0, 9) == 0) begin
                    sym = SYM_W'($urandom_range(0, ALPHA - 1));
                end else begin
                    sym = SYM_W'(base + $urandom_range(0, width - 1));
                end
                send_symbol(sym, start, 1'b0, '0, '0);
            end
        end
        i_in_valid <= 1'b0;
        no_idle = 1'b0;

        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d symbols over %0d started strings, %0d repeated-symbol hits.",
                 n_symbols, n_strings, n_repeats);
        $display("%0d results checked under %0d modulus writes, with one %0d-cycle output stall.",
                 n_results, n_mod_writes, LONG_HOLD);
        if (n_errors == 0 && pending_counts.size() == 0) begin
            $display("distinct_subsequence_counter_unit_tb OK");
        end else begin
            $display("distinct_subsequence_counter_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
